// ===== sv/abde_pkg.sv =====
// Shared types and constants of the branch decode and evaluate block.
`timescale 1ns / 1ps

package abde_pkg;

	// Opcode patterns and masks of the recognised instruction groups
	localparam logic [31:0] OP_BCOND   = 32'h5400_0000;
	localparam logic [31:0] MASK_BCOND = 32'hFF00_0000;
	localparam logic [31:0] MASK_CMPTST = 32'h7E00_0000;
	localparam logic [31:0] OP_CMP     = 32'h3400_0000;
	localparam logic [31:0] OP_TST     = 32'h3600_0000;
	localparam logic [31:0] MASK_SEL   = 32'h7FE0_0000;
	localparam logic [31:0] OP_SEL     = 32'h1A80_0000;

	localparam int OFF_W = 21;	// byte offset of a 19-bit word immediate

	typedef enum logic [2:0] {
		KIND_BCOND = 3'd0,
		KIND_CBZ   = 3'd1,
		KIND_CBNZ  = 3'd2,
		KIND_TBZ   = 3'd3,
		KIND_TBNZ  = 3'd4,
		KIND_CSEL  = 3'd5,
		KIND_WATCH = 3'd6,
		KIND_ERROR = 3'd7
	} kind_t;

	// Classified item, handed from the front end to the back end
	typedef struct packed {
		kind_t             kind;
		logic              rbit;
		logic              taken;
		logic [3:0]        cond;
		logic [4:0]        ridx;
		logic [OFF_W-1:0]  off;
		logic [63:0]       pc;
		logic [63:0]       next;
		logic [63:0]       rstart;
		logic [63:0]       rend;
	} dec_t;

	// Finished result
	typedef struct packed {
		kind_t       kind;
		logic        rbit;
		logic        taken;
		logic [63:0] target;
		logic [3:0]  cond;
		logic [4:0]  ridx;
		logic        leaves;
		logic [63:0] exit_addr;
	} res_t;

endpackage

// ===== sv/abde_front.sv =====
// Front end: decode and classify each instruction, evaluate its condition.
`timescale 1ns / 1ps

module abde_front (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic [31:0]     instr_word,
	input  logic [63:0]     pc,
	input  logic [3:0]      flags_nzcv,
	input  logic [63:0]     reg_value,
	input  logic            watch_enable,
	input  logic            watch_is_64bit,
	input  logic [63:0]     region_start,
	input  logic [63:0]     region_end,
	output logic            dec_valid,
	input  logic            dec_ready,
	output abde_pkg::dec_t  dec
);
	import abde_pkg::*;

	logic  v_s1;
	dec_t  dec_s1;
	dec_t  dec_c;
	logic  zero32;
	logic  zero64;
	logic  tbit;
	logic  alias_inv;
	logic [3:0] sel_cond;

	function automatic logic cond_holds(input logic [3:0] code, input logic [3:0] nzcv);
		logic n, z, c, v, r;
		n = nzcv[3];
		z = nzcv[2];
		c = nzcv[1];
		v = nzcv[0];
		unique case (code)
			4'h0: r = z;
			4'h1: r = !z;
			4'h2: r = c;
			4'h3: r = !c;
			4'h4: r = n;
			4'h5: r = !n;
			4'h6: r = v;
			4'h7: r = !v;
			4'h8: r = c && !z;
			4'h9: r = !c || z;
			4'hA: r = (n == v);
			4'hB: r = (n != v);
			4'hC: r = !z && (n == v);
			4'hD: r = z || (n != v);
			default: r = 1'b1;
		endcase
		return r;
	endfunction

	assign zero32    = (reg_value[31:0] == 32'd0);
	assign zero64    = zero32 && (reg_value[63:32] == 32'd0);
	assign tbit      = reg_value[{instr_word[31], instr_word[23:19]}];
	assign alias_inv = (instr_word[11:10] != 2'b00) && (instr_word[9:5] == instr_word[20:16]);
	assign sel_cond  = instr_word[15:12] ^ {3'b000, alias_inv};

	always_comb begin
		dec_c        = '0;
		dec_c.pc     = pc;
		dec_c.next   = pc + 64'd4;
		dec_c.rstart = region_start;
		dec_c.rend   = region_end;
		dec_c.off    = OFF_W'(4);
		priority if ((instr_word & MASK_BCOND) == OP_BCOND) begin
			dec_c.kind  = KIND_BCOND;
			dec_c.cond  = instr_word[3:0];
			dec_c.taken = cond_holds(instr_word[3:0], flags_nzcv);
			dec_c.off   = {instr_word[23:5], 2'b00};
		end else if ((instr_word & MASK_CMPTST) == OP_CMP) begin
			dec_c.kind  = instr_word[24] ? KIND_CBNZ : KIND_CBZ;
			dec_c.ridx  = instr_word[4:0];
			dec_c.taken = instr_word[24] ^ (instr_word[31] ? zero64 : zero32);
			dec_c.off   = {instr_word[23:5], 2'b00};
		end else if ((instr_word & MASK_CMPTST) == OP_TST) begin
			dec_c.kind  = instr_word[24] ? KIND_TBNZ : KIND_TBZ;
			dec_c.ridx  = instr_word[4:0];
			dec_c.taken = !(instr_word[24] ^ tbit);
			dec_c.off   = {{5{instr_word[18]}}, instr_word[18:5], 2'b00};
		end else if ((instr_word & MASK_SEL) == OP_SEL) begin
			dec_c.kind  = KIND_CSEL;
			dec_c.cond  = sel_cond;
			dec_c.taken = cond_holds(sel_cond, flags_nzcv);
		end else if (watch_enable) begin
			dec_c.kind  = KIND_WATCH;
			dec_c.rbit  = watch_is_64bit ? !zero64 : !zero32;
		end else begin
			// error: every field but the kind reads as zero
			dec_c       = '0;
			dec_c.kind  = KIND_ERROR;
		end
		if (dec_c.kind != KIND_WATCH) begin
			dec_c.rbit = dec_c.taken;
		end
	end

	assign in_ready  = !v_s1 || dec_ready;
	assign dec_valid = v_s1;
	assign dec       = dec_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (in_ready) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			dec_s1 <= dec_c;
		end
	end

endmodule

// ===== sv/abde_queue.sv =====
// Short queue of classified items between the front end and the back end.
`timescale 1ns / 1ps

module abde_queue #(
	parameter int DEPTH = 2
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push_valid,
	output logic            push_ready,
	input  abde_pkg::dec_t  push_data,
	output logic            pop_valid,
	input  logic            pop_ready,
	output abde_pkg::dec_t  pop_data
);
	import abde_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	dec_t            mem_q [DEPTH];
	logic [PW-1:0]   wptr_q;
	logic [PW-1:0]   rptr_q;
	logic [CW-1:0]   cnt_q;
	logic            push;
	logic            pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= push_data;
		end
	end

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DEPTH))
		else $error("queue fill count beyond depth");
	a_cnt_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("queue fill count missed a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0) |-> (wptr_q == rptr_q))
		else $error("queue pointers differ while empty");
`endif

endmodule

// ===== sv/abde_back.sv =====
// Back end: target address, region checks and the output register.
`timescale 1ns / 1ps

module abde_back (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            dec_valid,
	output logic            dec_ready,
	input  abde_pkg::dec_t  dec,
	output logic            res_valid,
	input  logic            res_ready,
	output abde_pkg::res_t  res
);
	import abde_pkg::*;

	typedef struct packed {
		kind_t       kind;
		logic        rbit;
		logic        taken;
		logic [3:0]  cond;
		logic [4:0]  ridx;
		logic [63:0] target;
		logic [63:0] next;
		logic [63:0] rstart;
		logic [63:0] rend;
		logic        fall_out;
	} exe_t;

	logic  v_s2;
	logic  v_s3;
	exe_t  exe_s2;
	res_t  res_s3;
	exe_t  exe_c;
	res_t  res_c;
	logic  ready_s3;

	// Stage 2: add the sign-extended offset, check the fall-through
	always_comb begin
		exe_c.kind     = dec.kind;
		exe_c.rbit     = dec.rbit;
		exe_c.taken    = dec.taken;
		exe_c.cond     = dec.cond;
		exe_c.ridx     = dec.ridx;
		exe_c.target   = dec.pc + {{(64 - OFF_W){dec.off[OFF_W-1]}}, dec.off};
		exe_c.next     = dec.next;
		exe_c.rstart   = dec.rstart;
		exe_c.rend     = dec.rend;
		exe_c.fall_out = (dec.next > dec.rend);
	end

	// Stage 3: check the taken target against both bounds, or use the fall-through check
	always_comb begin
		res_c.kind      = exe_s2.kind;
		res_c.rbit      = exe_s2.rbit;
		res_c.taken     = exe_s2.taken;
		res_c.target    = exe_s2.target;
		res_c.cond      = exe_s2.cond;
		res_c.ridx      = exe_s2.ridx;
		res_c.leaves    = exe_s2.taken
			? ((exe_s2.target < exe_s2.rstart) || (exe_s2.target > exe_s2.rend))
			: exe_s2.fall_out;
		res_c.exit_addr = exe_s2.taken ? exe_s2.target : exe_s2.next;
	end

	assign ready_s3  = !v_s3 || res_ready;
	assign dec_ready = !v_s2 || ready_s3;
	assign res_valid = v_s3;
	assign res       = res_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (dec_ready) begin
				v_s2 <= dec_valid;
			end
			if (ready_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (dec_valid && dec_ready) begin
			exe_s2 <= exe_c;
		end
		if (v_s2 && ready_s3) begin
			res_s3 <= res_c;
		end
	end

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.kind == KIND_ERROR) |->
		(!res_s3.taken && !res_s3.leaves && res_s3.target == 64'd0 && res_s3.exit_addr == 64'd0))
		else $error("error result carries nonzero fields");
	a_taken_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.taken) |-> (res_s3.exit_addr == res_s3.target))
		else $error("taken branch exits away from its target");
	a_watch: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.kind == KIND_WATCH) |->
		(!res_s3.taken && res_s3.target == res_s3.exit_addr))
		else $error("watch result marked taken or off fall-through");
	a_rbit: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && res_s3.kind != KIND_WATCH) |-> (res_s3.rbit == res_s3.taken))
		else $error("recorded bit differs from taken");
`endif

endmodule

// ===== sv/aarch64_branch_decode_evaluate.sv =====
// Top level of the AArch64 conditional branch decode and evaluate block.
`timescale 1ns / 1ps

// Channel   Dir  Width  Transfer when
// s_axis    in   296    s_axis_tvalid && s_axis_tready: one executed instruction
// m_axis    out  144    m_axis_tvalid && m_axis_tready: one evaluated result
//
// One transfer in and one out per cycle sustained while m_axis_tready stays high;
// every instruction gives one result. m_axis_tvalid rises once the transfer edge has
// loaded the front end decode register and the item has then passed a queue entry, the
// target adder stage and the region compare/output register, in that order.
// The queue between front and back end holds QUEUE_DEPTH items, so an output stall
// backs up into the queue before s_axis_tready drops.
// arst_n clears all valid flags and queue pointers; no clearing pass is needed.

module aarch64_branch_decode_evaluate #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// instr_word[31:0], pc[95:32], flags_nzcv[99:96], reg_value[163:100],
	// watch_enable[164], watch_is_64bit[165], region_start[229:166],
	// region_end[293:230], zero[295:294]
	input  logic [295:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// kind[2:0], result_bit[3], taken[4], branch_target[68:5], effective_cond[72:69],
	// register_index[77:73], leaves_region[78], exit_addr[142:79], zero[143]
	output logic [143:0] m_axis_tdata
);
	import abde_pkg::*;

	logic  fq_valid;
	logic  fq_ready;
	dec_t  fq_data;
	logic  qb_valid;
	logic  qb_ready;
	dec_t  qb_data;
	res_t  res;

	// Decode and classify; condition flags and register tests resolve here
	abde_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.instr_word     (s_axis_tdata[31:0]),
		.pc             (s_axis_tdata[95:32]),
		.flags_nzcv     (s_axis_tdata[99:96]),
		.reg_value      (s_axis_tdata[163:100]),
		.watch_enable   (s_axis_tdata[164]),
		.watch_is_64bit (s_axis_tdata[165]),
		.region_start   (s_axis_tdata[229:166]),
		.region_end     (s_axis_tdata[293:230]),
		.dec_valid      (fq_valid),
		.dec_ready      (fq_ready),
		.dec            (fq_data)
	);

	// Decouple the two halves so each can stall on its own
	abde_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fq_valid),
		.push_ready (fq_ready),
		.push_data  (fq_data),
		.pop_valid  (qb_valid),
		.pop_ready  (qb_ready),
		.pop_data   (qb_data)
	);

	// Target address, region exit and output register
	abde_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.dec_valid (qb_valid),
		.dec_ready (qb_ready),
		.dec       (qb_data),
		.res_valid (m_axis_tvalid),
		.res_ready (m_axis_tready),
		.res       (res)
	);

	// Pack the result, first field in the lowest bits, pad the top bit with zero
	assign m_axis_tdata = {1'b0, res.exit_addr, res.leaves, res.ridx, res.cond,
		res.target, res.taken, res.rbit, res.kind};

endmodule
